/* rtl/core/sdc_pkg.sv */
// Shared types and constants for the sector disk channel controller.
`timescale 1ns / 1ps

package sdc_pkg;

    // Field widths
    localparam int CODE_W   = 12;
    localparam int WORD_W   = 12;
    localparam int TRACK_W  = 7;
    localparam int HEAD_W   = 3;
    localparam int SECTOR_W = 7;
    localparam int ADDR_W   = 26;
    localparam int ACTION_W = 3;

    // Disk geometry
    localparam int HEAD_COUNT        = 8;
    localparam int SECTORS_PER_TRACK = 128;
    localparam int SECTOR_WORDS      = 338;

    // Function codes (octal)
    localparam logic [CODE_W-1:0] CODE_MASK   = 12'o7600;
    localparam logic [CODE_W-1:0] CODE_READ   = 12'o1000;
    localparam logic [CODE_W-1:0] CODE_WRITE  = 12'o1200;
    localparam logic [CODE_W-1:0] CODE_TRACK  = 12'o1400;
    localparam logic [CODE_W-1:0] CODE_HEAD   = 12'o1600;
    localparam logic [CODE_W-1:0] CODE_STATUS = 12'o1700;

    // Result action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE   = 3'd0,
        ACT_READ   = 3'd1,
        ACT_WRITE  = 3'd2,
        ACT_STATUS = 3'd3,
        ACT_ERROR  = 3'd4
    } t_action;

    // One input word
    typedef struct packed {
        logic              command;
        logic [CODE_W-1:0] function_code;
        logic              channel_full;
        logic [WORD_W-1:0] channel_word;
    } t_in_word;

    // One result word
    typedef struct packed {
        logic              accepted;
        t_action           action;
        logic [ADDR_W-1:0] store_address;
        logic [WORD_W-1:0] store_write_word;
        logic [WORD_W-1:0] channel_word_out;
        logic              channel_full_out;
    } t_out_word;

    // Controller state
    typedef struct packed {
        logic [TRACK_W-1:0]  track_reg;
        logic [HEAD_W-1:0]   head_reg;
        logic [SECTOR_W-1:0] sector_reg;
        logic [CODE_W-1:0]   active_function;
        logic [ADDR_W-1:0]   word_address;
        logic [SECTOR_W-1:0] status_word;
    } t_state;

endpackage

/* rtl/core/sdc_if.sv */
// Valid/ready channel interfaces for the controller input and result words.
`timescale 1ns / 1ps

interface sdc_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [11:0] function_code;
    logic        channel_full;
    logic [11:0] channel_word;

    modport source (output valid, command, function_code, channel_full, channel_word,
                    input ready);
    modport sink   (input valid, command, function_code, channel_full, channel_word,
                    output ready);
endinterface

interface sdc_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [2:0]  action;
    logic [25:0] store_address;
    logic [11:0] store_write_word;
    logic [11:0] channel_word_out;
    logic        channel_full_out;

    modport source (output valid, accepted, action, store_address, store_write_word,
                    channel_word_out, channel_full_out, input ready);
    modport sink   (input valid, accepted, action, store_address, store_write_word,
                    channel_word_out, channel_full_out, output ready);
endinterface

/* rtl/core/sdc_addr.sv */
// Sector start address: ((track*heads+head)*sectors+sector)*words, modulo 2^26.
`timescale 1ns / 1ps

module sdc_addr (
    input  logic [sdc_pkg::TRACK_W-1:0]  i_track,
    input  logic [sdc_pkg::HEAD_W-1:0]   i_head,
    input  logic [sdc_pkg::SECTOR_W-1:0] i_sector,
    output logic [sdc_pkg::ADDR_W-1:0]   o_addr
);
    import sdc_pkg::*;

    logic [ADDR_W-1:0] w_th;
    logic [ADDR_W-1:0] w_ths;

    // Constant multipliers only; the address width truncation gives the wrap
    always_comb begin
        w_th   = ADDR_W'(i_track) * ADDR_W'(HEAD_COUNT) + ADDR_W'(i_head);
        w_ths  = w_th * ADDR_W'(SECTORS_PER_TRACK) + ADDR_W'(i_sector);
        o_addr = w_ths * ADDR_W'(SECTOR_WORDS);
    end

endmodule

/* rtl/core/sdc_exec.sv */
// Per-word decode: next controller state and the result word.
`timescale 1ns / 1ps

module sdc_exec (
    input  sdc_pkg::t_state    i_st,
    input  sdc_pkg::t_in_word  i_item,
    output sdc_pkg::t_state    o_st_nxt,
    output sdc_pkg::t_out_word o_res
);
    import sdc_pkg::*;

    logic [ADDR_W-1:0] w_start;

    // Start address uses the sector carried in the new function code
    sdc_addr u_addr (
        .i_track  (i_st.track_reg),
        .i_head   (i_st.head_reg),
        .i_sector (i_item.function_code[SECTOR_W-1:0]),
        .o_addr   (w_start)
    );

    always_comb begin
        o_st_nxt = i_st;
        o_res    = '0;
        o_res.action           = ACT_NONE;
        o_res.channel_full_out = i_item.channel_full;

        if (!i_item.command) begin
            // Function code
            o_res.accepted = 1'b1;
            unique case (i_item.function_code & CODE_MASK)
                CODE_READ, CODE_WRITE: begin
                    o_st_nxt.active_function = i_item.function_code;
                    o_st_nxt.sector_reg      = i_item.function_code[SECTOR_W-1:0];
                    o_st_nxt.word_address    = w_start;
                end
                CODE_TRACK: begin
                    o_st_nxt.track_reg = i_item.function_code[TRACK_W-1:0];
                end
                CODE_HEAD: begin
                    if (i_item.function_code == CODE_STATUS) begin
                        o_st_nxt.active_function = i_item.function_code;
                        o_st_nxt.status_word     = i_st.sector_reg;
                        o_st_nxt.sector_reg      = i_st.sector_reg + SECTOR_W'(1);
                    end else begin
                        o_st_nxt.head_reg = i_item.function_code[HEAD_W-1:0];
                    end
                end
                default: begin
                    o_res.accepted = 1'b0;
                end
            endcase
        end else begin
            // I/O strobe, steered by the active function
            unique case (i_st.active_function & CODE_MASK)
                CODE_READ: begin
                    if (!i_item.channel_full) begin
                        o_res.action           = ACT_READ;
                        o_res.store_address    = i_st.word_address;
                        o_res.channel_full_out = 1'b1;
                        o_st_nxt.word_address  = i_st.word_address + ADDR_W'(1);
                    end
                end
                CODE_WRITE: begin
                    if (i_item.channel_full) begin
                        o_res.action           = ACT_WRITE;
                        o_res.store_address    = i_st.word_address;
                        o_res.store_write_word = i_item.channel_word;
                        o_res.channel_full_out = 1'b0;
                        o_st_nxt.word_address  = i_st.word_address + ADDR_W'(1);
                    end
                end
                CODE_TRACK: begin
                    o_res.action = ACT_NONE;
                end
                CODE_HEAD: begin
                    if (i_st.active_function == CODE_STATUS) begin
                        o_res.action             = ACT_STATUS;
                        o_res.channel_word_out   = WORD_W'(i_st.status_word);
                        o_res.channel_full_out   = 1'b1;
                        o_st_nxt.status_word     = '0;
                        o_st_nxt.active_function = '0;
                    end
                end
                default: begin
                    o_res.action = ACT_ERROR;
                end
            endcase
        end
    end

endmodule

/* rtl/core/sector_disk_channel_controller_core.sv */
// Top level of the sector disk channel controller: input stage, state and result stage.
`timescale 1ns / 1ps

// Takes one word per clock (function code or channel I/O strobe) unless held off by a stalled
// result, and returns exactly one result word per input word. A word is held in the input
// register, where the decode and the constant-multiplier sector address logic act on it, and
// is then captured in the result register together with the state update. The input side
// keeps accepting while a result waits, as long as its input stage is empty or the result
// register frees up in the same cycle; only a stalled result with a full input stage holds
// off new words. There is no clearing pass after reset.
module sector_disk_channel_controller_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdc_in_if.sink     i_in,
    sdc_out_if.source  o_out
);
    import sdc_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    t_state    r_st;

    t_state    n_st;
    t_out_word n_out;
    logic      w_adv;
    logic      w_move;
    logic      w_take;

    // Handshake control
    assign w_adv      = !r_out_valid || o_out.ready;
    assign w_move     = r_in_valid && w_adv;
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_take     = i_in.valid && i_in.ready;

    sdc_exec u_exec (
        .i_st     (r_st),
        .i_item   (r_in),
        .o_st_nxt (n_st),
        .o_res    (n_out)
    );

    // Valid flags and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_move) begin
                r_st <= n_st;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.command       <= i_in.command;
            r_in.function_code <= i_in.function_code;
            r_in.channel_full  <= i_in.channel_full;
            r_in.channel_word  <= i_in.channel_word;
        end
        if (w_move) begin
            r_out <= n_out;
        end
    end

    // Result channel
    assign o_out.valid            = r_out_valid;
    assign o_out.accepted         = r_out.accepted;
    assign o_out.action           = r_out.action;
    assign o_out.store_address    = r_out.store_address;
    assign o_out.store_write_word = r_out.store_write_word;
    assign o_out.channel_word_out = r_out.channel_word_out;
    assign o_out.channel_full_out = r_out.channel_full_out;

`ifndef SYNTH
    // Store transfers step the word address by one
    a_addr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && (n_out.action == ACT_READ || n_out.action == ACT_WRITE))
        |=> (r_st.word_address == $past(r_st.word_address) + ADDR_W'(1)))
        else $error("word address did not advance after store transfer");

    // Status delivery retires the status function
    a_status_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && n_out.action == ACT_STATUS)
        |=> (r_st.active_function == '0 && r_st.status_word == '0))
        else $error("status function not cleared after delivery");

    // Strobe results never carry an accept, and reads leave the channel full
    a_strobe_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action != ACT_NONE)
        |-> (!r_out.accepted && (r_out.action != ACT_READ || r_out.channel_full_out)))
        else $error("inconsistent strobe result");

    // A stalled result holds while the input stage keeps its word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready && r_in_valid) |=> (r_in_valid && $stable(r_st)))
        else $error("state changed during result stall");
`endif

endmodule
